>>> rtl/core/ffa_pkg.sv
`default_nettype none
package ffa_pkg;
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CK,
        ST_ALLOC_WR,
        ST_REM_RD,
        ST_REM_WR,
        ST_FREE_PREV,
        ST_FREE_DEC,
        ST_INS_RD,
        ST_INS_WR,
        ST_INS_NEW,
        ST_DONE
    } t_state;

    localparam logic       OP_ALLOC   = 1'b0;
    localparam logic       OP_FREE    = 1'b1;
    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_NOFIT  = 2'd1;
    localparam logic [1:0] STS_LOST   = 2'd2;
    localparam logic [31:0] RND_ADD   = 32'h0000_00ff;
    localparam logic [31:0] RND_MASK  = 32'hffff_ff00;
endpackage
`default_nettype wire

>>> rtl/core/ffa_ram.sv
`default_nettype none
module ffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/first_fit_free_list_allocator_top.sv
// Channel | Dir | Handshake        | Payload
// s_axis  | in  | tvalid/tready    | tdata: op, round_up, region_addr, region_size
// m_axis  | out | tvalid/tready    | tdata: alloc_addr, status, counters
// One item at a time; a read-modify-write walk over one entry memory port.
// Allocate: scans entries in turn, then shifts the later entries down on removal.
// Free: scans entries in turn, then shifts entries on insert or merge.
// Reset clears counters; no clearing pass.
// s_axis_tready falls while an item is at work or its result waits on m_axis.
`default_nettype none
module first_fit_free_list_allocator_top
    import ffa_pkg::*;
#(
    parameter int MAX_ENTRIES = 256,
    parameter int ADDR_BITS   = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    // op[0], round_up[1], region_addr[33:2], region_size[65:34], zero fill
    input  wire logic [71:0]   s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // alloc_addr[31:0], status[33:32], free_total[65:34], entry_count[74:66],
    // peak_count[83:75], lost_count[115:84], lost_bytes[147:116], zero fill
    output logic [151:0]       m_axis_tdata
);
    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = ADDR_BITS;
    localparam int EW = AW + 32;

    t_state r_state, n_state;
    logic          r_op;
    logic [AW-1:0] r_addr;
    logic [31:0]   r_size;
    logic [CW-1:0] r_used, r_peak;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_ins;
    logic [31:0]   r_total, r_lcnt, r_lbytes;
    logic [31:0]   r_grant;
    logic [1:0]    r_sts;
    logic [EW-1:0] r_prev;
    logic          r_have_prev;
    logic [EW-1:0] r_hold;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [AW-1:0] rd_st, pv_st;
    logic [31:0]   rd_len, pv_len, sz_in;
    logic [AW-1:0] fend, pv_end;
    logic [32:0]   sat_c, sat_b;

    ffa_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign rd_st  = rdata[EW-1:32];
    assign rd_len = rdata[31:0];
    assign pv_st  = r_prev[EW-1:32];
    assign pv_len = r_prev[31:0];
    assign fend   = r_addr + AW'(r_size);
    assign pv_end = pv_st + AW'(pv_len);
    assign sz_in  = s_axis_tdata[1] ? ((s_axis_tdata[65:34] + RND_ADD) & RND_MASK)
                                    : s_axis_tdata[65:34];
    assign sat_c  = {1'b0, r_lcnt} + 33'd1;
    assign sat_b  = {1'b0, r_lbytes} + {1'b0, r_size};

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_DONE);
    assign m_axis_tdata  = {4'd0, r_lbytes, r_lcnt, 9'(r_peak), 9'(r_used), r_total,
                            r_sts, r_grant};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used  <= '0;
            r_peak  <= '0;
            r_total <= '0;
            r_lcnt  <= '0;
            r_lbytes <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op   <= s_axis_tdata[0];
                        r_addr <= AW'(s_axis_tdata[33:2]);
                        r_size <= sz_in;
                        r_grant <= '0;
                        r_sts  <= STS_OK;
                        r_have_prev <= 1'b0;
                    end
                end
                ST_SCAN_CK: begin
                    if (r_i >= r_used) begin
                        if (r_op == OP_ALLOC) begin
                            r_sts <= STS_NOFIT;
                        end
                    end else if (r_op == OP_ALLOC) begin
                        if (rd_len >= r_size) begin
                            r_grant <= 32'(rd_st);
                            r_prev  <= {rd_st + AW'(r_size), rd_len - r_size};
                            r_total <= r_total - r_size;
                        end
                    end else if (!(rd_st > r_addr)) begin
                        r_prev <= rdata;
                        r_have_prev <= 1'b1;
                    end else begin
                        r_hold <= rdata;
                    end
                end
                ST_FREE_DEC: begin
                    r_ins <= r_i;
                end
                ST_REM_WR: begin
                    if (r_i >= r_used) begin
                        r_used <= r_used - CW'(1);
                    end
                end
                ST_FREE_PREV: begin
                    r_total <= r_total + r_size;
                end
                ST_INS_NEW: begin
                    if (r_used == CW'(MAX_ENTRIES)) begin
                        r_sts   <= STS_LOST;
                        r_lcnt  <= sat_c[32] ? '1 : sat_c[31:0];
                        r_lbytes <= sat_b[32] ? '1 : sat_b[31:0];
                    end else begin
                        r_total <= r_total + r_size;
                        r_used  <= r_used + CW'(1);
                        if (r_used + CW'(1) > r_peak) begin
                            r_peak <= r_used + CW'(1);
                        end
                    end
                end
                ST_INS_RD: begin
                    r_hold <= rdata;
                end
                default: begin
                end
            endcase
        end
    end

    // r_i: scan index; in shift states it walks the entries being moved
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        we      = 1'b0;
        waddr   = r_i[IW-1:0];
        wdata   = r_prev;
        raddr   = r_i[IW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                n_i = '0;
                if (s_axis_tvalid) begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_CK;
            end
            ST_SCAN_CK: begin
                if (r_i >= r_used) begin
                    n_state = (r_op == OP_ALLOC) ? ST_DONE : ST_FREE_DEC;
                end else if (r_op == OP_ALLOC) begin
                    if (rd_len >= r_size) begin
                        n_state = ST_ALLOC_WR;
                    end else begin
                        n_i = r_i + CW'(1);
                        n_state = ST_SCAN_RD;
                    end
                end else if (!(rd_st > r_addr)) begin
                    n_i = r_i + CW'(1);
                    n_state = ST_SCAN_RD;
                end else begin
                    n_state = ST_FREE_DEC;
                end
            end
            ST_ALLOC_WR: begin
                we = 1'b1;
                if (pv_len == '0) begin
                    n_i = r_i + CW'(1);
                    n_state = ST_REM_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_REM_RD: begin
                n_state = ST_REM_WR;
                if (r_i >= r_used) begin
                    n_state = ST_REM_WR;
                end
            end
            ST_REM_WR: begin
                if (r_i >= r_used) begin
                    n_state = ST_DONE;
                end else begin
                    we    = 1'b1;
                    waddr = IW'(r_i - CW'(1));
                    wdata = rdata;
                    n_i   = r_i + CW'(1);
                    n_state = ST_REM_RD;
                end
            end
            ST_FREE_DEC: begin
                if (r_have_prev && pv_end == r_addr) begin
                    n_state = ST_FREE_PREV;
                end else if (r_i < r_used && fend == r_hold[EW-1:32]) begin
                    we    = 1'b1;
                    wdata = {r_addr, r_hold[31:0] + r_size};
                    n_state = ST_FREE_PREV;
                end else begin
                    n_state = ST_INS_NEW;
                end
            end
            ST_FREE_PREV: begin
                // merge into previous entry, optionally absorbing the next one
                if (r_have_prev && pv_end == r_addr) begin
                    we    = 1'b1;
                    waddr = IW'(r_i - CW'(1));
                    if (r_i < r_used && fend == r_hold[EW-1:32]) begin
                        wdata = {pv_st, pv_len + r_size + r_hold[31:0]};
                        n_i   = r_i + CW'(1);
                        n_state = ST_REM_RD;
                    end else begin
                        wdata = {pv_st, pv_len + r_size};
                        n_state = ST_DONE;
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_INS_NEW: begin
                if (r_used == CW'(MAX_ENTRIES)) begin
                    n_state = ST_DONE;
                end else begin
                    n_i = r_used;
                    n_state = ST_INS_RD;
                end
            end
            ST_INS_RD: begin
                // r_used already incremented; shift entries [i..used-2] up by one
                raddr = IW'(r_i - CW'(1));
                n_state = ST_INS_WR;
            end
            ST_INS_WR: begin
                we = 1'b1;
                if (r_i == r_ins) begin
                    wdata = {r_addr, r_size};
                    n_state = ST_DONE;
                end else begin
                    wdata = rdata;
                    n_i = r_i - CW'(1);
                    n_state = ST_INS_RD;
                end
            end
            ST_DONE: begin
                if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(MAX_ENTRIES)) else $error("entry count beyond table");
    a_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak >= r_used) else $error("peak below entry count");
    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !m_axis_tready) |=> r_state == ST_DONE)
        else $error("result dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
`endif
endmodule
`default_nettype wire
